FILE: rtl/grid_bilinear_distortion_map_assert.svh
// Assertion macros shared by the RTL of the distortion map.
`ifndef GRID_BILINEAR_DISTORTION_MAP_ASSERT_SVH
`define GRID_BILINEAR_DISTORTION_MAP_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define GBDM_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("gbdm assertion failed");
`define GBDM_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("gbdm assertion failed");
`else
`define GBDM_ASSERT(lbl, clk, rst, prop)
`define GBDM_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

FILE: rtl/gbdm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package gbdm_pkg;

   localparam int MAX_CELLS_X = 16;
   localparam int MAX_CELLS_Y = 16;

   // Node index width: a node column runs from 0 to MAX_CELLS_X.
   localparam int NX_W = $clog2(MAX_CELLS_X + 1);
   localparam int NY_W = $clog2(MAX_CELLS_Y + 1);

   // The store is split into four banks by column and row parity, so the
   // four corners of any cell fall into four different banks.
   localparam int BANK_COLS  = (MAX_CELLS_X + 2) / 2;
   localparam int BANK_ROWS  = (MAX_CELLS_Y + 2) / 2;
   localparam int BANK_DEPTH = BANK_COLS * BANK_ROWS;
   localparam int BANK_AW    = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;

   localparam int T_W = 43;

   localparam int MUL_AW = 96;
   localparam int MUL_BW = 48;
   localparam int MUL_PW = MUL_AW + MUL_BW;

   localparam int LANE_LAT = 7;

   localparam logic [2:0] CSR_ORIGIN_X   = 3'd0;
   localparam logic [2:0] CSR_ORIGIN_Y   = 3'd1;
   localparam logic [2:0] CSR_INV_STEP_X = 3'd2;
   localparam logic [2:0] CSR_INV_STEP_Y = 3'd3;
   localparam logic [2:0] CSR_CELLS_X    = 3'd4;
   localparam logic [2:0] CSR_CELLS_Y    = 3'd5;

   localparam logic signed [95:0] SAT_HI = 96'sd2147483647;
   localparam logic signed [95:0] SAT_LO = -96'sd2147483648;

   typedef struct packed {
      logic signed [31:0] origin_x;
      logic signed [31:0] origin_y;
      logic [31:0]        inv_step_x;
      logic [31:0]        inv_step_y;
      logic [4:0]         cells_x;
      logic [4:0]         cells_y;
   } cfg_type;

   typedef struct packed {
      logic            vld;
      logic [NX_W-1:0] cell_col;
      logic [NY_W-1:0] cell_row;
   } front_out_type;

   // Clips a wide signed value to 32 bits; the top bit flags a clip.
   function automatic logic [32:0] sat32(input logic signed [95:0] v);
      logic [32:0] r;
      if (v > SAT_HI) begin
         r = {1'b1, 32'h7FFFFFFF};
      end else if (v < SAT_LO) begin
         r = {1'b1, 32'h80000000};
      end else begin
         r = {1'b0, v[31:0]};
      end
      return r;
   endfunction

endpackage
`default_nettype wire

FILE: rtl/gbdm_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module gbdm_ram #(
   parameter int DEPTH = 81,
   parameter int AW    = 7,
   parameter int DW    = 64
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [DW-1:0] wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [DW-1:0] rd_data
);

   logic [DW-1:0] mem [DEPTH];
   logic [DW-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

FILE: rtl/gbdm_mul.sv
`timescale 1ns / 1ps
`default_nettype none
module gbdm_mul
   import gbdm_pkg::*;
(
   input  logic                     clock,
   input  logic                     en,
   input  logic signed [MUL_AW-1:0] a,
   input  logic signed [MUL_BW-1:0] b,
   output logic signed [MUL_PW-1:0] p
);

   // Two-stage signed multiplier: 24-bit digits, partial products in the
   // first stage, their weighted sum in the second.
   logic signed [24:0] a_dig [4];
   logic signed [24:0] b_dig [2];
   logic signed [49:0] pp_in [8];
   logic signed [49:0] pp_ff [8];
   logic signed [MUL_PW-1:0] sum_in;
   logic signed [MUL_PW-1:0] sum_ff;

   always_comb begin
      a_dig[0] = signed'({1'b0, a[23:0]});
      a_dig[1] = signed'({1'b0, a[47:24]});
      a_dig[2] = signed'({1'b0, a[71:48]});
      a_dig[3] = signed'({a[95], a[95:72]});
      b_dig[0] = signed'({1'b0, b[23:0]});
      b_dig[1] = signed'({b[47], b[47:24]});
      for (int i = 0; i < 4; i++) begin
         for (int j = 0; j < 2; j++) begin
            pp_in[i*2+j] = a_dig[i] * b_dig[j];
         end
      end
   end

   always_comb begin
      sum_in = '0;
      for (int k = 0; k < 8; k++) begin
         sum_in = sum_in + (MUL_PW'(pp_ff[k]) <<< (24 * ((k / 2) + (k % 2))));
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pp_ff  <= pp_in;
         sum_ff <= sum_in;
      end
   end

   assign p = sum_ff;

endmodule
`default_nettype wire

FILE: rtl/gbdm_front.sv
`timescale 1ns / 1ps
`default_nettype none
module gbdm_front
   import gbdm_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  logic                  in_vld,
   input  logic                  command,
   input  logic [4:0]            node_col,
   input  logic [4:0]            node_row,
   input  logic signed [31:0]    node_pos_x,
   input  logic signed [31:0]    node_pos_y,
   input  logic signed [31:0]    point_x,
   input  logic signed [31:0]    point_y,
   input  cfg_type               cfg,
   output logic signed [31:0]    p_x [4],
   output logic signed [31:0]    p_y [4],
   output logic signed [T_W-1:0] t,
   output logic signed [T_W-1:0] u,
   output front_out_type         status
);

   // Stage 1: offset from the origin.
   logic               v1_ff, cmd1_ff;
   logic [4:0]         col1_ff, row1_ff;
   logic signed [31:0] posx1_ff, posy1_ff;
   logic signed [32:0] dx1_ff, dy1_ff;
   // Stage 2: grid coordinates in Q26.16.
   logic               v2_ff, cmd2_ff;
   logic [4:0]         col2_ff, row2_ff;
   logic signed [31:0] posx2_ff, posy2_ff;
   logic signed [41:0] gx2_ff, gy2_ff;
   logic signed [65:0] prodx, prody;
   // Stage 3: cell, fractions and corner nodes.
   logic                  v3_ff;
   logic [NX_W-1:0]       cx3_ff, cx_in;
   logic [NY_W-1:0]       cy3_ff, cy_in;
   logic signed [T_W-1:0] t3_ff, u3_ff, t_in, u_in;

   logic [BANK_AW-1:0] rd_addr [4];
   logic [BANK_AW-1:0] wr_addr;
   logic [3:0]         wr_en;
   logic [63:0]        rd_data [4];
   logic               load_ok;

   assign prodx = dx1_ff * signed'({1'b0, cfg.inv_step_x});
   assign prody = dy1_ff * signed'({1'b0, cfg.inv_step_y});

   always_comb begin
      int nx, ny;
      int col_i, row_i;
      logic signed [25:0] crx, cry;
      nx  = (cfg.cells_x == 5'd0) ? 1 :
            ((int'(cfg.cells_x) > MAX_CELLS_X) ? MAX_CELLS_X : int'(cfg.cells_x));
      ny  = (cfg.cells_y == 5'd0) ? 1 :
            ((int'(cfg.cells_y) > MAX_CELLS_Y) ? MAX_CELLS_Y : int'(cfg.cells_y));
      crx = gx2_ff[41:16];
      cry = gy2_ff[41:16];
      if (crx < 0) begin
         crx = '0;
      end else if (crx > 26'(nx - 1)) begin
         crx = 26'(nx - 1);
      end
      if (cry < 0) begin
         cry = '0;
      end else if (cry > 26'(ny - 1)) begin
         cry = 26'(ny - 1);
      end
      cx_in = crx[NX_W-1:0];
      cy_in = cry[NY_W-1:0];
      t_in  = T_W'(gx2_ff) - T_W'(signed'({1'b0, cx_in, 16'h0000}));
      u_in  = T_W'(gy2_ff) - T_W'(signed'({1'b0, cy_in, 16'h0000}));
      // Bank b holds nodes whose row parity is b[1] and column parity b[0].
      for (int b = 0; b < 4; b++) begin
         col_i = (cx_in[0] == b[0]) ? int'(cx_in) : int'(cx_in) + 1;
         row_i = (cy_in[0] == b[1]) ? int'(cy_in) : int'(cy_in) + 1;
         rd_addr[b] = BANK_AW'((row_i / 2) * BANK_COLS + col_i / 2);
      end
   end

   // Loads write at the same stage as maps read, so request order is kept.
   always_comb begin
      load_ok = v2_ff && !cmd2_ff && (int'(col2_ff) <= MAX_CELLS_X)
                && (int'(row2_ff) <= MAX_CELLS_Y);
      wr_addr = BANK_AW'((int'(row2_ff) / 2) * BANK_COLS + int'(col2_ff) / 2);
      for (int b = 0; b < 4; b++) begin
         wr_en[b] = en && load_ok && (row2_ff[0] == b[1]) && (col2_ff[0] == b[0]);
      end
   end

   for (genvar g = 0; g < 4; g++) begin : g_bank
      gbdm_ram #(
         .DEPTH (BANK_DEPTH),
         .AW    (BANK_AW),
         .DW    (64)
      ) u_bank (
         .clock   (clock),
         .wr_en   (wr_en[g]),
         .wr_addr (wr_addr),
         .wr_data ({posy2_ff, posx2_ff}),
         .rd_en   (en),
         .rd_addr (rd_addr[g]),
         .rd_data (rd_data[g])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_vld;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff && cmd2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cmd1_ff  <= command;
         col1_ff  <= node_col;
         row1_ff  <= node_row;
         posx1_ff <= node_pos_x;
         posy1_ff <= node_pos_y;
         dx1_ff   <= 33'(point_x) - 33'(cfg.origin_x);
         dy1_ff   <= 33'(point_y) - 33'(cfg.origin_y);
         cmd2_ff  <= cmd1_ff;
         col2_ff  <= col1_ff;
         row2_ff  <= row1_ff;
         posx2_ff <= posx1_ff;
         posy2_ff <= posy1_ff;
         gx2_ff   <= prodx[65:24];
         gy2_ff   <= prody[65:24];
         cx3_ff   <= cx_in;
         cy3_ff   <= cy_in;
         t3_ff    <= t_in;
         u3_ff    <= u_in;
      end
   end

   always_comb begin
      logic [1:0] bsel;
      for (int k = 0; k < 4; k++) begin
         bsel   = 2'(k) ^ {cy3_ff[0], cx3_ff[0]};
         p_x[k] = rd_data[bsel][31:0];
         p_y[k] = rd_data[bsel][63:32];
      end
   end

   assign t               = t3_ff;
   assign u               = u3_ff;
   assign status.vld      = v3_ff;
   assign status.cell_col = cx3_ff;
   assign status.cell_row = cy3_ff;

endmodule
`default_nettype wire

FILE: rtl/gbdm_lane.sv
`timescale 1ns / 1ps
`default_nettype none
module gbdm_lane
   import gbdm_pkg::*;
(
   input  logic                  clock,
   input  logic                  en,
   input  logic signed [31:0]    p00,
   input  logic signed [31:0]    p10,
   input  logic signed [31:0]    p01,
   input  logic signed [31:0]    p11,
   input  logic signed [T_W-1:0] t,
   input  logic signed [T_W-1:0] u,
   input  logic [31:0]           inv_step_x,
   input  logic [31:0]           inv_step_y,
   output logic signed [31:0]    mapped,
   output logic signed [31:0]    jac_x,
   output logic signed [31:0]    jac_y,
   output logic                  clip
);

   localparam logic signed [123:0] RND_MAP = 124'sh80000000;
   localparam logic signed [111:0] RND_JAC = 112'sh8000000000;

   // The bilinear sum is A*2^32 + t*B*2^16 + u*Q with Q = C*2^16 + D*t,
   // and the slopes are R*inv_x and Q*inv_y with R = B*2^16 + D*u.
   logic signed [31:0]     a4_ff, a5_ff, a6_ff, a7_ff, a8_ff, a9_ff;
   logic signed [32:0]     b4_ff, b5_ff, b6_ff, c4_ff, c5_ff, c6_ff;
   logic signed [33:0]     d4_ff;
   logic signed [T_W-1:0]  t4_ff, u4_ff, u5_ff, u6_ff, u7_ff;
   logic signed [75:0]     tb7_ff, tb8_ff, tb9_ff;
   logic signed [77:0]     q7_ff, r7_ff;
   logic signed [MUL_PW-1:0] dt_p, du_p, tb_p, uq_p, rx_p, qy_p;
   logic signed [123:0]    s_sum;
   logic signed [111:0]    jx_sum, jy_sum;
   logic signed [91:0]     m10_ff;
   logic signed [71:0]     jx10_ff, jy10_ff;
   logic [32:0]            sat_m, sat_x, sat_y;

   always_ff @(posedge clock) begin
      if (en) begin
         a4_ff <= p00;
         b4_ff <= 33'(p10) - 33'(p00);
         c4_ff <= 33'(p01) - 33'(p00);
         d4_ff <= 34'(p11) - 34'(p10) - 34'(p01) + 34'(p00);
         t4_ff <= t;
         u4_ff <= u;
         a5_ff <= a4_ff;
         a6_ff <= a5_ff;
         b5_ff <= b4_ff;
         b6_ff <= b5_ff;
         c5_ff <= c4_ff;
         c6_ff <= c5_ff;
         u5_ff <= u4_ff;
         u6_ff <= u5_ff;
         a7_ff <= a6_ff;
         u7_ff <= u6_ff;
         tb7_ff <= 76'(tb_p);
         q7_ff <= (78'(c6_ff) <<< 16) + 78'(dt_p);
         r7_ff <= (78'(b6_ff) <<< 16) + 78'(du_p);
         a8_ff <= a7_ff;
         a9_ff <= a8_ff;
         tb8_ff <= tb7_ff;
         tb9_ff <= tb8_ff;
         m10_ff  <= 92'(s_sum >>> 32);
         jx10_ff <= 72'(jx_sum >>> 40);
         jy10_ff <= 72'(jy_sum >>> 40);
      end
   end

   gbdm_mul u_mul_dt (.clock(clock), .en(en), .a(MUL_AW'(t4_ff)), .b(MUL_BW'(d4_ff)),
                      .p(dt_p));
   gbdm_mul u_mul_du (.clock(clock), .en(en), .a(MUL_AW'(u4_ff)), .b(MUL_BW'(d4_ff)),
                      .p(du_p));
   gbdm_mul u_mul_tb (.clock(clock), .en(en), .a(MUL_AW'(t4_ff)), .b(MUL_BW'(b4_ff)),
                      .p(tb_p));
   gbdm_mul u_mul_uq (.clock(clock), .en(en), .a(MUL_AW'(q7_ff)), .b(MUL_BW'(u7_ff)),
                      .p(uq_p));
   gbdm_mul u_mul_rx (.clock(clock), .en(en), .a(MUL_AW'(r7_ff)),
                      .b(signed'({16'h0000, inv_step_x})), .p(rx_p));
   gbdm_mul u_mul_qy (.clock(clock), .en(en), .a(MUL_AW'(q7_ff)),
                      .b(signed'({16'h0000, inv_step_y})), .p(qy_p));

   // Round to nearest with ties upwards before the arithmetic shift.
   always_comb begin
      s_sum  = (124'(a9_ff) <<< 32) + (124'(tb9_ff) <<< 16) + 124'(uq_p) + RND_MAP;
      jx_sum = 112'(rx_p) + RND_JAC;
      jy_sum = 112'(qy_p) + RND_JAC;
   end

   assign sat_m  = sat32(96'(m10_ff));
   assign sat_x  = sat32(96'(jx10_ff));
   assign sat_y  = sat32(96'(jy10_ff));
   assign mapped = sat_m[31:0];
   assign jac_x  = sat_x[31:0];
   assign jac_y  = sat_y[31:0];
   assign clip   = sat_m[32] | sat_x[32] | sat_y[32];

endmodule
`default_nettype wire

FILE: rtl/grid_bilinear_distortion_map.sv
// Bilinear grid distortion map.
// Requests arrive on the req_ channel (valid/stall): a load request writes one
// grid node into the node store and gives no response, a map request gives
// one response on the rsp_ channel with the mapped point, its Jacobian, the
// clamped cell and a saturation flag.
// The pipeline takes one request in every cycle while rsp_stall does not
// hold it; the rate is set by the fully pipelined datapath of eleven
// stages, of which the two-stage multipliers take four.
// Responses come in request order.
// When rsp_stall is high with a response waiting, the whole pipeline holds
// and req_stall rises; nothing is lost or repeated.
// Reset clears all valid bits and sets the registers to origin 0, step 1.0
// and one cell on each axis. The node store is not cleared: a map request
// may only touch nodes that were loaded before it.
// Registers are written over csr_ with csr_wr_en, csr_index and csr_wdata.
// The user writes them only while no request is in flight; not enforced here.
`timescale 1ns / 1ps
`default_nettype none
`include "grid_bilinear_distortion_map_assert.svh"
module grid_bilinear_distortion_map
   import gbdm_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_command,
   input  logic [4:0]         req_node_col,
   input  logic [4:0]         req_node_row,
   input  logic signed [31:0] req_node_pos_x,
   input  logic signed [31:0] req_node_pos_y,
   input  logic signed [31:0] req_point_x,
   input  logic signed [31:0] req_point_y,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_mapped_x,
   output logic signed [31:0] rsp_mapped_y,
   output logic signed [31:0] rsp_jac_xx,
   output logic signed [31:0] rsp_jac_yx,
   output logic signed [31:0] rsp_jac_xy,
   output logic signed [31:0] rsp_jac_yy,
   output logic [3:0]         rsp_cell_col,
   output logic [3:0]         rsp_cell_row,
   output logic               rsp_saturated,
   input  logic               csr_wr_en,
   input  logic [2:0]         csr_index,
   input  logic [31:0]        csr_wdata
);

   cfg_type        cfg_ff;
   logic           en;
   logic signed [31:0]    p_x [4];
   logic signed [31:0]    p_y [4];
   logic signed [T_W-1:0] t, u;
   front_out_type  status;
   logic signed [31:0] mx, my, jxx, jxy, jyx, jyy;
   logic           clip_x, clip_y;

   logic [LANE_LAT-1:0] lv_ff;
   logic [NX_W-1:0]     lcol_ff [LANE_LAT];
   logic [NY_W-1:0]     lrow_ff [LANE_LAT];

   logic               rsp_valid_ff, rsp_saturated_ff;
   logic signed [31:0] rsp_mapped_x_ff, rsp_mapped_y_ff;
   logic signed [31:0] rsp_jac_xx_ff, rsp_jac_yx_ff, rsp_jac_xy_ff, rsp_jac_yy_ff;
   logic [3:0]         rsp_cell_col_ff, rsp_cell_row_ff;

   assign en        = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !en;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.origin_x   <= '0;
         cfg_ff.origin_y   <= '0;
         cfg_ff.inv_step_x <= 32'h01000000;
         cfg_ff.inv_step_y <= 32'h01000000;
         cfg_ff.cells_x    <= 5'd1;
         cfg_ff.cells_y    <= 5'd1;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_ORIGIN_X:   cfg_ff.origin_x   <= csr_wdata;
            CSR_ORIGIN_Y:   cfg_ff.origin_y   <= csr_wdata;
            CSR_INV_STEP_X: cfg_ff.inv_step_x <= csr_wdata;
            CSR_INV_STEP_Y: cfg_ff.inv_step_y <= csr_wdata;
            CSR_CELLS_X:    cfg_ff.cells_x    <= csr_wdata[4:0];
            CSR_CELLS_Y:    cfg_ff.cells_y    <= csr_wdata[4:0];
            default: ;
         endcase
      end
   end

   gbdm_front u_front (
      .clock      (clock),
      .reset      (reset),
      .en         (en),
      .in_vld     (req_valid),
      .command    (req_command),
      .node_col   (req_node_col),
      .node_row   (req_node_row),
      .node_pos_x (req_node_pos_x),
      .node_pos_y (req_node_pos_y),
      .point_x    (req_point_x),
      .point_y    (req_point_y),
      .cfg        (cfg_ff),
      .p_x        (p_x),
      .p_y        (p_y),
      .t          (t),
      .u          (u),
      .status     (status)
   );

   gbdm_lane u_lane_x (
      .clock      (clock),
      .en         (en),
      .p00        (p_x[0]),
      .p10        (p_x[1]),
      .p01        (p_x[2]),
      .p11        (p_x[3]),
      .t          (t),
      .u          (u),
      .inv_step_x (cfg_ff.inv_step_x),
      .inv_step_y (cfg_ff.inv_step_y),
      .mapped     (mx),
      .jac_x      (jxx),
      .jac_y      (jxy),
      .clip       (clip_x)
   );

   gbdm_lane u_lane_y (
      .clock      (clock),
      .en         (en),
      .p00        (p_y[0]),
      .p10        (p_y[1]),
      .p01        (p_y[2]),
      .p11        (p_y[3]),
      .t          (t),
      .u          (u),
      .inv_step_x (cfg_ff.inv_step_x),
      .inv_step_y (cfg_ff.inv_step_y),
      .mapped     (my),
      .jac_x      (jyx),
      .jac_y      (jyy),
      .clip       (clip_y)
   );

   // Valid bits and cell indices travel alongside the two lanes.
   always_ff @(posedge clock) begin
      if (reset) begin
         lv_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         lv_ff        <= {lv_ff[LANE_LAT-2:0], status.vld};
         rsp_valid_ff <= lv_ff[LANE_LAT-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         lcol_ff[0] <= status.cell_col;
         lrow_ff[0] <= status.cell_row;
         for (int i = 1; i < LANE_LAT; i++) begin
            lcol_ff[i] <= lcol_ff[i-1];
            lrow_ff[i] <= lrow_ff[i-1];
         end
         rsp_mapped_x_ff  <= mx;
         rsp_mapped_y_ff  <= my;
         rsp_jac_xx_ff    <= jxx;
         rsp_jac_yx_ff    <= jyx;
         rsp_jac_xy_ff    <= jxy;
         rsp_jac_yy_ff    <= jyy;
         rsp_cell_col_ff  <= 4'(lcol_ff[LANE_LAT-1]);
         rsp_cell_row_ff  <= 4'(lrow_ff[LANE_LAT-1]);
         rsp_saturated_ff <= clip_x | clip_y;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_mapped_x  = rsp_mapped_x_ff;
   assign rsp_mapped_y  = rsp_mapped_y_ff;
   assign rsp_jac_xx    = rsp_jac_xx_ff;
   assign rsp_jac_yx    = rsp_jac_yx_ff;
   assign rsp_jac_xy    = rsp_jac_xy_ff;
   assign rsp_jac_yy    = rsp_jac_yy_ff;
   assign rsp_cell_col  = rsp_cell_col_ff;
   assign rsp_cell_row  = rsp_cell_row_ff;
   assign rsp_saturated = rsp_saturated_ff;

   `GBDM_ASSERT(a_tail_to_rsp, clock, reset, (en && lv_ff[LANE_LAT-1]) |=> rsp_valid_ff)
   `GBDM_ASSERT(a_hold_on_stall, clock, reset, (!en) |=> (lv_ff == $past(lv_ff)))
   `GBDM_ASSERT_ALWAYS(a_reset_clears, clock, reset |=> !rsp_valid_ff)

endmodule
`default_nettype wire
